// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files of the length histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SSSH_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define SSSH_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sssh_pkg.sv -----
// Package of shared constants, codes and helpers for the length histogram block.
package sssh_pkg;

  // Default sizes of the histograms and of the group store.
  localparam int LENGTH_BINS_DEF = 1024;
  localparam int GROUP_DEPTH_DEF = 64;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int START_W  = 32;
  localparam int LENGTH_W = 16;
  localparam int RBIN_W   = 10;
  localparam int THR_W    = 7;
  localparam int COUNT_W  = 32;

  // Threshold value after reset.
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2);

  // Command codes carried by the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_TAG   = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef logic [COUNT_W-1:0] count_t;

  // Saturating increment of a bin count.
  function automatic count_t sat_inc(input count_t value);
    sat_inc = (value == '1) ? value : value + count_t'(1);
  endfunction

endpackage

// ----- hw/rtl/same_start_length_histogram.sv -----
// Top level: group tracking and saturating length histograms for same-start tags.
//
//   Channel   Direction  Handshake                       Payload
//   in        input      in_valid_i / in_stall_o         kind, tag_*, read_bin, read_rest
//   out       output     out_valid_o / out_stall_i       bin_count
//   config    input      group_threshold_we_i            group_threshold_i
//
// A plus-strand tag with the open start is written straight into the group store; a tag
// that closes a group of n tags starts a flush that walks the group store and does one
// read-modify-write of the histogram memory per stored tag. A close of a non-empty group
// starts the same flush, a tag beyond a full group does one read-modify-write, and a bin
// read waits on the output register. After reset a clearing pass zeroes all
// 2 * 2**clog2(LENGTH_BINS) histogram entries, during which no item is accepted. A stalled result does not block tags.
`include "assert_macros.svh"

module same_start_length_histogram #(
  parameter int LENGTH_BINS = sssh_pkg::LENGTH_BINS_DEF,
  parameter int GROUP_DEPTH = sssh_pkg::GROUP_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration
  input  logic                           group_threshold_we_i,
  input  logic [sssh_pkg::THR_W-1:0]     group_threshold_i,
  // Input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sssh_pkg::KIND_W-1:0]    kind_i,
  input  logic [sssh_pkg::START_W-1:0]   tag_start_i,
  input  logic                           tag_plus_strand_i,
  input  logic [sssh_pkg::LENGTH_W-1:0]  tag_length_i,
  input  logic [sssh_pkg::RBIN_W-1:0]    read_bin_i,
  input  logic                           read_rest_i,
  // Result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sssh_pkg::COUNT_W-1:0]   bin_count_o
);

  localparam int BIN_W   = $clog2(LENGTH_BINS);
  localparam int HA_W    = BIN_W + 1;
  localparam int HDEPTH  = 2 ** HA_W;
  localparam int GIDX_W  = $clog2(GROUP_DEPTH);
  localparam int SIZE_W  = $clog2(GROUP_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FL_START,
    ST_FL_HRD,
    ST_FL_HWR,
    ST_BUMP_RD,
    ST_BUMP_WR,
    ST_READ
  } state_e;

  // Control and item registers.
  state_e                         state_q, state_d;
  logic [sssh_pkg::THR_W-1:0]     thr_q, thr_d;
  logic [sssh_pkg::START_W-1:0]   gstart_q, gstart_d;
  logic [SIZE_W-1:0]              size_q, size_d;
  logic [SIZE_W-1:0]              cnt_q, cnt_d;
  logic [HA_W-1:0]                clr_q, clr_d;
  logic [BIN_W-1:0]               bin_q, bin_d;
  logic                           sel_q, sel_d;
  logic                           pend_q, pend_d;
  logic                           rd_zero_q, rd_zero_d;
  logic                           out_valid_q, out_valid_d;
  sssh_pkg::count_t               bin_count_q, bin_count_d;

  // Memory ports.
  sssh_pkg::count_t               hist_mem [HDEPTH];
  logic                           hist_we, hist_re;
  logic [HA_W-1:0]                hist_waddr, hist_raddr;
  sssh_pkg::count_t               hist_wdata, hist_rdata_q;

  logic [BIN_W-1:0]               grp_mem [GROUP_DEPTH];
  logic                           grp_we, grp_re;
  logic [GIDX_W-1:0]              grp_waddr, grp_raddr;
  logic [BIN_W-1:0]               grp_wdata, grp_rdata_q;

  logic                           in_acc, out_acc;
  logic [BIN_W-1:0]               tag_bin;
  logic                           size_dup, full_dup, bin_in_range, flush_last;
  logic [SIZE_W-1:0]              cnt_next;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;

  // Lengths beyond the last bin are clamped into it.
  assign tag_bin = ({1'b0, tag_length_i} > (sssh_pkg::LENGTH_W + 1)'(LENGTH_BINS - 1))
                   ? BIN_W'(LENGTH_BINS - 1) : BIN_W'(tag_length_i);

  // Duplicate decisions for the open group and for a tag beyond a full group.
  assign size_dup     = 32'(size_q) >= 32'(thr_q);
  assign full_dup     = 32'(GROUP_DEPTH) >= 32'(thr_q);
  assign bin_in_range = 32'(read_bin_i) < 32'(LENGTH_BINS);
  assign cnt_next     = cnt_q + SIZE_W'(1);
  assign flush_last   = (cnt_next == size_q);

  // Next-state logic and memory port control.
  always_comb begin
    state_d     = state_q;
    thr_d       = group_threshold_we_i ? group_threshold_i : thr_q;
    gstart_d    = gstart_q;
    size_d      = size_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    bin_d       = bin_q;
    sel_d       = sel_q;
    pend_d      = pend_q;
    rd_zero_d   = rd_zero_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    bin_count_d = bin_count_q;

    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_waddr = {sel_q, grp_rdata_q};
    hist_raddr = {sel_q, grp_rdata_q};
    hist_wdata = sssh_pkg::sat_inc(hist_rdata_q);
    grp_we     = 1'b0;
    grp_re     = 1'b0;
    grp_waddr  = size_q[GIDX_W-1:0];
    grp_wdata  = tag_bin;
    grp_raddr  = cnt_q[GIDX_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one histogram entry per cycle.
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        hist_wdata = '0;
        clr_d      = clr_q + HA_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_i)
            sssh_pkg::KIND_TAG: begin
              if (tag_plus_strand_i) begin
                bin_d = tag_bin;
                if (tag_start_i != gstart_q) begin
                  gstart_d = tag_start_i;
                  if (size_q != '0) begin
                    // A new start closes the open group before the tag is stored.
                    sel_d   = !size_dup;
                    pend_d  = 1'b1;
                    cnt_d   = '0;
                    state_d = ST_FL_START;
                  end else begin
                    grp_we = 1'b1;
                    size_d = size_q + SIZE_W'(1);
                  end
                end else if (32'(size_q) < 32'(GROUP_DEPTH)) begin
                  grp_we = 1'b1;
                  size_d = size_q + SIZE_W'(1);
                end else begin
                  // The group store is full: count the tag at once.
                  sel_d   = !full_dup;
                  state_d = ST_BUMP_RD;
                end
              end
            end
            sssh_pkg::KIND_CLOSE: begin
              if (size_q != '0) begin
                sel_d   = !size_dup;
                pend_d  = 1'b0;
                cnt_d   = '0;
                state_d = ST_FL_START;
              end
            end
            sssh_pkg::KIND_READ: begin
              hist_re    = 1'b1;
              hist_raddr = {read_rest_i, BIN_W'(read_bin_i)};
              rd_zero_d  = !bin_in_range;
              state_d    = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FL_START: begin
        grp_re  = 1'b1;
        state_d = ST_FL_HRD;
      end
      ST_FL_HRD: begin
        // The stored length selects the bin to read.
        hist_re = 1'b1;
        state_d = ST_FL_HWR;
      end
      ST_FL_HWR: begin
        hist_we = 1'b1;
        if (flush_last) begin
          if (pend_q) begin
            grp_we    = 1'b1;
            grp_waddr = '0;
            grp_wdata = bin_q;
            size_d    = SIZE_W'(1);
          end else begin
            size_d = '0;
          end
          state_d = ST_IDLE;
        end else begin
          cnt_d     = cnt_next;
          grp_re    = 1'b1;
          grp_raddr = cnt_next[GIDX_W-1:0];
          state_d   = ST_FL_HRD;
        end
      end
      ST_BUMP_RD: begin
        hist_re    = 1'b1;
        hist_raddr = {sel_q, bin_q};
        state_d    = ST_BUMP_WR;
      end
      ST_BUMP_WR: begin
        hist_we    = 1'b1;
        hist_waddr = {sel_q, bin_q};
        state_d    = ST_IDLE;
      end
      ST_READ: begin
        // Load the result once the output register is free.
        if (!out_valid_q || out_acc) begin
          out_valid_d = 1'b1;
          bin_count_d = rd_zero_q ? '0 : hist_rdata_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      thr_q       <= sssh_pkg::THRESHOLD_RESET;
      gstart_q    <= '0;
      size_q      <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      gstart_q    <= gstart_d;
      size_q      <= size_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q       <= bin_d;
    sel_q       <= sel_d;
    rd_zero_q   <= rd_zero_d;
    bin_count_q <= bin_count_d;
  end

  // Histogram memory: duplicated counts in the lower half, rest counts in the upper half.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_q <= hist_mem[hist_raddr];
    end
  end

  // Group store holding the clamped lengths of the open group.
  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_mem[grp_waddr] <= grp_wdata;
    end
    if (grp_re) begin
      grp_rdata_q <= grp_mem[grp_raddr];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign bin_count_o = bin_count_q;

  // The group never holds more tags than the store has entries.
  `SSSH_ASSERT(a_size_bound, 32'(size_q) <= 32'(GROUP_DEPTH), "group size beyond store depth")

  // The flush walk only visits stored entries of a non-empty group.
  `SSSH_ASSERT_IMP(a_flush_cnt,
    (state_q == ST_FL_HRD) || (state_q == ST_FL_HWR),
    (cnt_q < size_q) && (size_q != '0), "flush index outside the group")

  // A result appears only after a bin read has waited for its data.
  `SSSH_ASSERT_IMP(a_out_source,
    $rose(out_valid_q), $past(state_q == ST_READ), "result without a bin read")

endmodule

// ----- tb/same_start_length_histogram_checker.sv -----
// Checker that predicts the histogram bin counts and compares them with the block's results.
`timescale 1ns / 100ps

module same_start_length_histogram_checker #(
  parameter int LENGTH_BINS = sssh_pkg::LENGTH_BINS_DEF,
  parameter int GROUP_DEPTH = sssh_pkg::GROUP_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          group_threshold_we_i,
  input  logic [sssh_pkg::THR_W-1:0]    group_threshold_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [sssh_pkg::KIND_W-1:0]   kind_i,
  input  logic [sssh_pkg::START_W-1:0]  tag_start_i,
  input  logic                          tag_plus_strand_i,
  input  logic [sssh_pkg::LENGTH_W-1:0] tag_length_i,
  input  logic [sssh_pkg::RBIN_W-1:0]   read_bin_i,
  input  logic                          read_rest_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [sssh_pkg::COUNT_W-1:0]  bin_count_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  // Predicted state of the block.
  logic [sssh_pkg::THR_W-1:0]   dup_threshold;
  logic [sssh_pkg::START_W-1:0] open_start;
  int unsigned                  open_size;
  int unsigned                  open_lengths [GROUP_DEPTH];
  sssh_pkg::count_t             dup_counts [LENGTH_BINS];
  sssh_pkg::count_t             rest_counts [LENGTH_BINS];

  // Bin counts still owed by the block, oldest first.
  sssh_pkg::count_t             owed_counts [$];
  int                           mismatches;

  // Adds one to a bin, holding at the largest count.
  function automatic void bump_bin(input bit to_dup, input int unsigned bin);
    if (bin < LENGTH_BINS) begin
      if (to_dup) begin
        if (dup_counts[bin] != '1) dup_counts[bin] = dup_counts[bin] + 1'b1;
      end else begin
        if (rest_counts[bin] != '1) rest_counts[bin] = rest_counts[bin] + 1'b1;
      end
    end
  endfunction

  // Moves the lengths of the open group into the histogram that its size selects.
  function automatic void close_open_group();
    bit to_dup;
    to_dup = (open_size >= dup_threshold);
    for (int unsigned k = 0; k < open_size && k < GROUP_DEPTH; k++) begin
      bump_bin(to_dup, open_lengths[k]);
    end
    open_size = 0;
  endfunction

  // A plus-strand tag: a new start closes the group, a full group counts the tag at once.
  function automatic void take_plus_tag(input logic [sssh_pkg::START_W-1:0] start,
                                        input logic [sssh_pkg::LENGTH_W-1:0] length);
    int unsigned bin;
    bin = (length > LENGTH_BINS - 1) ? LENGTH_BINS - 1 : length;
    if (start != open_start) begin
      close_open_group();
      open_start = start;
    end
    if (open_size < GROUP_DEPTH) begin
      open_lengths[open_size] = bin;
      open_size++;
    end else begin
      bump_bin(GROUP_DEPTH >= dup_threshold, bin);
    end
  endfunction

  // Tracks configuration, accepted items and accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    sssh_pkg::count_t got;
    sssh_pkg::count_t want;
    sssh_pkg::count_t read_value;
    if (!rst_ni) begin
      dup_threshold = sssh_pkg::THRESHOLD_RESET;
      open_start    = '0;
      open_size     = 0;
      for (int b = 0; b < LENGTH_BINS; b++) begin
        dup_counts[b]  = '0;
        rest_counts[b] = '0;
      end
      owed_counts.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (group_threshold_we_i) dup_threshold = group_threshold_i;

      // Results are taken before new items, as no result leaves in the cycle of its item.
      if (out_valid_i && !out_stall_i) begin
        got = bin_count_i;
        if (owed_counts.size() == 0) begin
          $error("bin_count: expected no result, actual %0d", got);
          mismatches++;
        end else begin
          want = owed_counts.pop_front();
          if (got !== want) begin
            $error("bin_count: expected %0d, actual %0d", want, got);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (kind_i)
          sssh_pkg::KIND_TAG: begin
            if (tag_plus_strand_i) take_plus_tag(tag_start_i, tag_length_i);
          end
          sssh_pkg::KIND_CLOSE: close_open_group();
          sssh_pkg::KIND_READ: begin
            if (read_bin_i < LENGTH_BINS) begin
              read_value = read_rest_i ? rest_counts[read_bin_i] : dup_counts[read_bin_i];
            end else begin
              read_value = '0;
            end
            owed_counts = {owed_counts, read_value};
          end
          default: ;
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= owed_counts.size();
    end
  end

endmodule

// ----- tb/same_start_length_histogram_test.sv -----
// Testbench top: drives tags, closes and bin reads into the block and gives the verdict.
`timescale 1ns / 100ps

module same_start_length_histogram_test;

  // The one kind code with no meaning to the block.
  localparam logic [sssh_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Longest internal walk: the flush of a full group.
  localparam int FLUSH_CYCLES = 2 * sssh_pkg::GROUP_DEPTH_DEF + 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 210;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          thr_we = 1'b0;
  logic [sssh_pkg::THR_W-1:0]    thr_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [sssh_pkg::KIND_W-1:0]   kind = sssh_pkg::KIND_TAG;
  logic [sssh_pkg::START_W-1:0]  tag_start = '0;
  logic                          tag_plus = 1'b0;
  logic [sssh_pkg::LENGTH_W-1:0] tag_length = '0;
  logic [sssh_pkg::RBIN_W-1:0]   read_bin = '0;
  logic                          read_rest = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [sssh_pkg::COUNT_W-1:0]  bin_count;
  int                            fail_count;
  int                            pending;

  // Stimulus controls, some of them shared with the receiving side.
  bit                            quiet = 1'b0;
  bit                            sender_gaps = 1'b0;
  bit                            hold_req = 1'b0;
  logic [sssh_pkg::START_W-1:0]  next_start = '0;
  int unsigned                   recent_bins [8] = '{0, 1, 2, 5, 15, 512, 1022, 1023};
  int                            items_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  same_start_length_histogram dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .group_threshold_we_i(thr_we),
    .group_threshold_i   (thr_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (kind),
    .tag_start_i         (tag_start),
    .tag_plus_strand_i   (tag_plus),
    .tag_length_i        (tag_length),
    .read_bin_i          (read_bin),
    .read_rest_i         (read_rest),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .bin_count_o         (bin_count)
  );

  same_start_length_histogram_checker checker_i (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .group_threshold_we_i(thr_we),
    .group_threshold_i   (thr_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .kind_i              (kind),
    .tag_start_i         (tag_start),
    .tag_plus_strand_i   (tag_plus),
    .tag_length_i        (tag_length),
    .read_bin_i          (read_bin),
    .read_rest_i         (read_rest),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .bin_count_i         (bin_count),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // Receiving side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        held = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(0, 18)) @(posedge clk);
      end
    end
  end

  // Offers one item, sometimes after a gap, and returns at the edge that accepts it.
  task automatic send_item(input logic [sssh_pkg::KIND_W-1:0] k,
                           input logic [sssh_pkg::START_W-1:0] start,
                           input logic plus, input logic [sssh_pkg::LENGTH_W-1:0] length,
                           input logic [sssh_pkg::RBIN_W-1:0] bin, input logic rest);
    if (!quiet && sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    tag_start  <= start;
    tag_plus   <= plus;
    tag_length <= length;
    read_bin   <= bin;
    read_rest  <= rest;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k != KIND_UNUSED && !(k == sssh_pkg::KIND_TAG && !plus)) items_sent++;
  endtask

  // Unused fields of each kind carry random values.
  task automatic send_tag(input logic [sssh_pkg::START_W-1:0] start, input logic plus,
                          input logic [sssh_pkg::LENGTH_W-1:0] length);
    send_item(sssh_pkg::KIND_TAG, start, plus, length,
              (sssh_pkg::RBIN_W)'($urandom), 1'($urandom));
  endtask

  task automatic send_close();
    send_item(sssh_pkg::KIND_CLOSE, $urandom, 1'($urandom), (sssh_pkg::LENGTH_W)'($urandom),
              (sssh_pkg::RBIN_W)'($urandom), 1'($urandom));
  endtask

  task automatic send_read(input logic [sssh_pkg::RBIN_W-1:0] bin, input logic rest);
    send_item(sssh_pkg::KIND_READ, $urandom, 1'($urandom), (sssh_pkg::LENGTH_W)'($urandom),
              bin, rest);
  endtask

  // Lengths cluster on a few bins so that reads find counts; the bin is remembered.
  function automatic logic [sssh_pkg::LENGTH_W-1:0] pick_length();
    logic [sssh_pkg::LENGTH_W-1:0] len;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)      len = (sssh_pkg::LENGTH_W)'($urandom_range(0, 15));
    else if (sel < 6) len = (sssh_pkg::LENGTH_W)'($urandom);
    else if (sel < 8) len = (sssh_pkg::LENGTH_W)'($urandom_range(1020, 1023));
    else              len = (sssh_pkg::LENGTH_W)'($urandom_range(1024, 65535));
    recent_bins[$urandom_range(0, 7)] = (len > 1023) ? 1023 : len;
    return len;
  endfunction

  function automatic logic [sssh_pkg::RBIN_W-1:0] pick_bin();
    if ($urandom_range(0, 9) < 7) begin
      return (sssh_pkg::RBIN_W)'(recent_bins[$urandom_range(0, 7)]);
    end
    return (sssh_pkg::RBIN_W)'($urandom);
  endfunction

  // A sorted group of plus-strand tags with the odd minus-strand tag among them.
  task automatic send_group(input int unsigned size);
    if ($urandom_range(0, 9) == 0) next_start = $urandom;
    else next_start = next_start + $urandom_range(1, 5000);
    for (int unsigned i = 0; i < size; i++) begin
      if ($urandom_range(0, 9) == 0) send_tag(next_start, 1'b0, pick_length());
      send_tag(next_start, 1'b1, pick_length());
    end
  endtask

  // Lowers valid and waits until every owed bin count has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // The register is written only once the block has drained and finished any flush.
  task automatic set_threshold(input logic [sssh_pkg::THR_W-1:0] value);
    wait_for_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    thr_we   <= 1'b1;
    thr_data <= value;
    @(posedge clk);
    thr_we <= 1'b0;
  endtask

  // Run limit, well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned thresholds [6];
    int unsigned sel;
    int unsigned phase_start;
    thresholds = '{0, 64, 1, 63, 2, 5};
    thresholds[5] = $urandom_range(3, 40);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset threshold of two.
    send_tag(32'd0, 1'b1, 16'd5);
    send_tag(32'd0, 1'b1, 16'hFFFF);
    send_tag(32'd0, 1'b0, 16'd7);
    send_tag(32'd10, 1'b1, 16'd1023);
    send_close();
    send_close();
    send_tag(32'd10, 1'b1, 16'd1024);
    send_tag(32'hFFFF_FFFF, 1'b1, 16'd0);
    send_item(KIND_UNUSED, $urandom, 1'b1, (sssh_pkg::LENGTH_W)'($urandom),
              (sssh_pkg::RBIN_W)'($urandom), 1'($urandom));
    send_read(10'd5, 1'b0);
    send_read(10'd1023, 1'b0);
    send_read(10'd1023, 1'b1);
    send_read(10'd0, 1'b1);
    send_close();
    send_read(10'd0, 1'b1);
    send_read(10'd0, 1'b0);
    send_read(10'd512, 1'b1);
    send_tag(32'hFFFF_FFFF, 1'b1, 16'd3);
    send_tag(32'hFFFF_FFFF, 1'b1, 16'd3);
    send_tag(32'h0000_0001, 1'b1, 16'd4);
    send_read(10'd3, 1'b0);
    send_close();
    send_read(10'd4, 1'b1);
    send_read(10'd3, 1'b0);

    // Random phases, one threshold each.
    for (int p = 0; p < 6; p++) begin
      set_threshold((sssh_pkg::THR_W)'(thresholds[p]));
      if (p == 5) quiet = 1'b1;
      if (p == 1) begin
        // Long hold-off on results while reads keep coming, so the input backs up.
        hold_req = 1'b1;
        repeat (24) send_read(pick_bin(), 1'($urandom));
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) sender_gaps = ~sender_gaps;
        if (p == 2 && items_sent - phase_start > PHASE_ITEMS / 2 &&
            items_sent - phase_start < PHASE_ITEMS / 2 + 3) begin
          wait_for_results();
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          sel = $urandom_range(0, 99);
          if (sel < 60)      send_group($urandom_range(1, 4));
          else if (sel < 88) send_group($urandom_range(1, (thresholds[p] + 3 > 70) ?
                                                          70 : thresholds[p] + 3));
          else               send_group($urandom_range(60, 70));
        end else if (sel < 82) begin
          send_read(pick_bin(), 1'($urandom));
        end else if (sel < 88) begin
          send_close();
        end else if (sel < 92) begin
          send_item(KIND_UNUSED, $urandom, 1'($urandom), (sssh_pkg::LENGTH_W)'($urandom),
                    (sssh_pkg::RBIN_W)'($urandom), 1'($urandom));
        end else begin
          // Broken order: a tag anywhere, on either strand.
          send_tag($urandom, 1'($urandom), pick_length());
        end
      end
    end

    // Drain, let any flush finish, then give the verdict.
    wait_for_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
